@@ rtl/assert_macros.svh @@
// assertion helpers used by dlbd_parser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("check failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("check failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/dlbd_pkg.sv @@
package dlbd_pkg;

	localparam int COUNT_WIDTH = 31;
	localparam int RL_W = 27;
	localparam int BPP_W = 2;
	localparam int NR_W = 16;
	localparam int RB_W = RL_W + BPP_W;
	localparam int EXP_W = RB_W + NR_W;
	localparam int CMP_W = (EXP_W > COUNT_WIDTH) ? EXP_W : COUNT_WIDTH;
	localparam int CFG_W = 27;
	localparam int IDX_W = 3;

	// register indexes
	localparam logic [IDX_W-1:0] REG_ARMED = 3'd0;
	localparam logic [IDX_W-1:0] REG_RECORD_LENGTH = 3'd1;
	localparam logic [IDX_W-1:0] REG_BYTES_PER_POINT = 3'd2;
	localparam logic [IDX_W-1:0] REG_MULTI_RECORD = 3'd3;
	localparam logic [IDX_W-1:0] REG_NUM_RECORDS = 3'd4;

	// parser phases
	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_NDIG = 2'd1;
	localparam logic [1:0] PH_LEN = 2'd2;
	localparam logic [1:0] PH_DATA = 2'd3;

	localparam logic [7:0] CHAR_HASH = 8'h23;

	typedef struct packed {
		logic armed;
		logic [RL_W-1:0] record_length;
		logic [BPP_W-1:0] bytes_per_point;
		logic multi_record;
		logic [NR_W-1:0] num_records;
	} cfg_t;

	typedef struct packed {
		logic armed;
		logic clear;
		logic hold;
	} ctl_t;

endpackage

@@ rtl/dlbd_size.sv @@
module dlbd_size (
	input logic clk,
	input dlbd_pkg::cfg_t cfg,
	output logic [dlbd_pkg::EXP_W-1:0] expected
);

	logic [dlbd_pkg::RB_W-1:0] rl_w;
	logic [dlbd_pkg::RB_W-1:0] rl_bpp;
	logic [dlbd_pkg::NR_W-1:0] frames;
	logic [dlbd_pkg::EXP_W-1:0] expected_q;

	// bytes_per_point is at most 3: shift and add, no multiplier
	always_comb begin
		rl_w = dlbd_pkg::RB_W'(cfg.record_length);
		unique case (cfg.bytes_per_point)
			2'd0: rl_bpp = '0;
			2'd1: rl_bpp = rl_w;
			2'd2: rl_bpp = rl_w << 1;
			default: rl_bpp = rl_w + (rl_w << 1);
		endcase
		frames = cfg.multi_record ? cfg.num_records : dlbd_pkg::NR_W'(1);
	end

	always_ff @(posedge clk) begin
		expected_q <= dlbd_pkg::EXP_W'(rl_bpp * frames);
	end

	assign expected = expected_q;

endmodule

@@ rtl/dlbd_parser.sv @@
`include "assert_macros.svh"

module dlbd_parser (
	input logic clk,
	input logic arst_n,
	input dlbd_pkg::ctl_t ctl,
	input logic [dlbd_pkg::EXP_W-1:0] expected,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] rx_byte,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] payload_byte,
	output logic last_byte,
	output logic header_error
);

	localparam int ACC_W = dlbd_pkg::COUNT_WIDTH + 4;

	logic s1_valid_q;
	logic [7:0] byte_s1;
	logic advance;

	logic [1:0] phase_q, phase_d;
	logic [3:0] digits_q, digits_d;
	logic [dlbd_pkg::COUNT_WIDTH-1:0] acc_q, acc_d;
	logic ovf_q, ovf_d;
	logic bad_q, bad_d;
	logic [dlbd_pkg::COUNT_WIDTH-1:0] left_q, left_d;

	logic produce;
	logic [7:0] res_byte;
	logic res_last;
	logic res_err;

	logic out_valid_q;
	logic [7:0] payload_q;
	logic last_q;
	logic err_q;

	logic hex_ok;
	logic [3:0] hex_n;
	logic is_digit;
	logic [7:0] dig_off;
	logic [ACC_W-1:0] acc_w;
	logic [ACC_W-1:0] acc_next;
	logic acc_big;
	logic hdr_bad;

	assign advance = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !ctl.hold && (!s1_valid_q || advance);

	// digit count character: 1..9, a..f, A..F
	always_comb begin
		hex_ok = 1'b1;
		hex_n = 4'd0;
		if (byte_s1 >= 8'h31 && byte_s1 <= 8'h39) begin
			hex_n = byte_s1[3:0];
		end else if (byte_s1 >= 8'h61 && byte_s1 <= 8'h66) begin
			hex_n = byte_s1[3:0] + 4'd9;
		end else if (byte_s1 >= 8'h41 && byte_s1 <= 8'h46) begin
			hex_n = byte_s1[3:0] + 4'd9;
		end else begin
			hex_ok = 1'b0;
		end
	end

	// decimal accumulate, overflow past the count width
	always_comb begin
		is_digit = (byte_s1 >= 8'h30) && (byte_s1 <= 8'h39);
		dig_off = byte_s1 - 8'h30;
		acc_w = ACC_W'(acc_q);
		acc_next = (acc_w << 3) + (acc_w << 1) + ACC_W'(dig_off[3:0]);
		acc_big = |acc_next[ACC_W-1:dlbd_pkg::COUNT_WIDTH];
	end

	always_comb begin
		phase_d = phase_q;
		digits_d = digits_q;
		acc_d = acc_q;
		ovf_d = ovf_q;
		bad_d = bad_q;
		left_d = left_q;
		produce = 1'b0;
		res_byte = 8'd0;
		res_last = 1'b0;
		res_err = 1'b0;
		hdr_bad = 1'b0;
		if (advance && ctl.armed) begin
			unique case (phase_q)
				dlbd_pkg::PH_HUNT: begin
					if (byte_s1 == dlbd_pkg::CHAR_HASH) begin
						phase_d = dlbd_pkg::PH_NDIG;
					end
				end
				dlbd_pkg::PH_NDIG: begin
					if (hex_ok) begin
						digits_d = hex_n;
						acc_d = '0;
						ovf_d = 1'b0;
						bad_d = 1'b0;
						phase_d = dlbd_pkg::PH_LEN;
					end else begin
						produce = 1'b1;
						res_err = 1'b1;
						phase_d = dlbd_pkg::PH_HUNT;
						digits_d = '0;
						acc_d = '0;
						ovf_d = 1'b0;
						bad_d = 1'b0;
						left_d = '0;
					end
				end
				dlbd_pkg::PH_LEN: begin
					if (is_digit) begin
						if (!ovf_q) begin
							if (acc_big) begin
								ovf_d = 1'b1;
							end else begin
								acc_d = acc_next[dlbd_pkg::COUNT_WIDTH-1:0];
							end
						end
					end else begin
						bad_d = 1'b1;
					end
					digits_d = digits_q - 4'd1;
					if (digits_d == 4'd0) begin
						hdr_bad = bad_d || ovf_d || (acc_d == '0) ||
							(dlbd_pkg::CMP_W'(acc_d) != dlbd_pkg::CMP_W'(expected));
						if (hdr_bad) begin
							produce = 1'b1;
							res_err = 1'b1;
							phase_d = dlbd_pkg::PH_HUNT;
							acc_d = '0;
							ovf_d = 1'b0;
							bad_d = 1'b0;
							left_d = '0;
						end else begin
							left_d = acc_d;
							phase_d = dlbd_pkg::PH_DATA;
						end
					end
				end
				default: begin
					produce = 1'b1;
					res_byte = byte_s1;
					if (left_q <= dlbd_pkg::COUNT_WIDTH'(1)) begin
						res_last = 1'b1;
						phase_d = dlbd_pkg::PH_HUNT;
						digits_d = '0;
						acc_d = '0;
						ovf_d = 1'b0;
						bad_d = 1'b0;
						left_d = '0;
					end else begin
						left_d = left_q - dlbd_pkg::COUNT_WIDTH'(1);
					end
				end
			endcase
		end
		// arming write wipes the parser
		if (ctl.clear) begin
			phase_d = dlbd_pkg::PH_HUNT;
			digits_d = '0;
			acc_d = '0;
			ovf_d = 1'b0;
			bad_d = 1'b0;
			left_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q <= dlbd_pkg::PH_HUNT;
			digits_q <= '0;
			acc_q <= '0;
			ovf_q <= 1'b0;
			bad_q <= 1'b0;
			left_q <= '0;
		end else begin
			if (in_valid && in_ready) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= produce;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			phase_q <= phase_d;
			digits_q <= digits_d;
			acc_q <= acc_d;
			ovf_q <= ovf_d;
			bad_q <= bad_d;
			left_q <= left_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
		if (advance && produce) begin
			payload_q <= res_byte;
			last_q <= res_last;
			err_q <= res_err;
		end
	end

	assign out_valid = out_valid_q;
	assign payload_byte = payload_q;
	assign last_byte = last_q;
	assign header_error = err_q;

	`ASSERT_ALWAYS(a_err_clean, clk, arst_n,
		!(out_valid_q && err_q) || (payload_q == 8'd0 && !last_q))
	`ASSERT_NEXT(a_disarmed_quiet, clk, arst_n, advance && !ctl.armed, !out_valid_q)
	`ASSERT_ALWAYS(a_data_has_bytes, clk, arst_n,
		phase_q != dlbd_pkg::PH_DATA || left_q != '0)

endmodule

@@ rtl/definite_length_block_deframer.sv @@
// definite length block deframer
// input channel: one received byte per beat on rx_byte (in_valid / in_ready)
// output channel: zero or one result beat per input byte (out_valid / out_ready)
//   carrying payload_byte, last_byte and header_error
// a header is '#', one hex digit n (1..f), n decimal digits of byte count;
// the count must equal record_length * bytes_per_point * frames, after which
// that many payload beats follow, the final one with last_byte set
// a bad header gives one beat with header_error set and payload_byte zero
// an accepted byte is held in the input register, and its result is registered
// into the result register and shown on out_valid once the output is free
// throughput: one byte per cycle, set by the parser update, unless the output or a config write stalls it
// the input side keeps taking beats while a result waits at the output,
// and stalls only once both the input register and result register are full,
// or after a config write (cfg_we), which lands at once; in_ready drops for the
// next cycle while the expected block size register catches up
// reset: disarmed, record_length 1, bytes_per_point 1, single record,
// parser hunting for '#', both pipeline registers empty
module definite_length_block_deframer (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [dlbd_pkg::IDX_W-1:0] cfg_index,
	input logic [dlbd_pkg::CFG_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] rx_byte,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] payload_byte,
	output logic last_byte,
	output logic header_error
);

	dlbd_pkg::cfg_t cfg_q;
	logic hold_q;
	dlbd_pkg::ctl_t ctl;
	logic [dlbd_pkg::EXP_W-1:0] expected;

	// configuration register file, write only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.armed <= 1'b0;
			cfg_q.record_length <= dlbd_pkg::RL_W'(1);
			cfg_q.bytes_per_point <= dlbd_pkg::BPP_W'(1);
			cfg_q.multi_record <= 1'b0;
			cfg_q.num_records <= dlbd_pkg::NR_W'(1);
			hold_q <= 1'b0;
		end else begin
			// block input in the cycle after a write so the size product is current
			hold_q <= cfg_we;
			if (cfg_we) begin
				unique case (cfg_index)
					dlbd_pkg::REG_ARMED: cfg_q.armed <= cfg_data[0];
					dlbd_pkg::REG_RECORD_LENGTH:
						cfg_q.record_length <= cfg_data[dlbd_pkg::RL_W-1:0];
					dlbd_pkg::REG_BYTES_PER_POINT:
						cfg_q.bytes_per_point <= cfg_data[dlbd_pkg::BPP_W-1:0];
					dlbd_pkg::REG_MULTI_RECORD: cfg_q.multi_record <= cfg_data[0];
					dlbd_pkg::REG_NUM_RECORDS:
						cfg_q.num_records <= cfg_data[dlbd_pkg::NR_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// writing the arm bit always restarts the parser
	assign ctl.armed = cfg_q.armed;
	assign ctl.clear = cfg_we && (cfg_index == dlbd_pkg::REG_ARMED);
	assign ctl.hold = hold_q;

	dlbd_size u_size (
		.clk(clk),
		.cfg(cfg_q),
		.expected(expected)
	);

	dlbd_parser u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.expected(expected),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.payload_byte(payload_byte),
		.last_byte(last_byte),
		.header_error(header_error)
	);

endmodule

@@ dv/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// ascii codes used by the header format
	localparam logic [7:0] CH_0 = "0";
	localparam logic [7:0] CH_1 = "1";
	localparam logic [7:0] CH_9 = "9";
	localparam logic [7:0] CH_LA = "a";
	localparam logic [7:0] CH_LF = "f";
	localparam logic [7:0] CH_UA = "A";
	localparam logic [7:0] CH_UF = "F";
	localparam logic [7:0] CH_LF_NL = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	localparam logic [63:0] COUNT_MAX = (64'd1 << dlbd_pkg::COUNT_WIDTH) - 64'd1;
	localparam int SETTLE_CYCLES = 6;    // pipeline drain plus margin
	localparam int HOLD_CYCLES = 64;     // long receiver hold-off
	localparam int STALL_LIMIT = 4000;   // cycles with no beat on either side

	typedef struct packed {
		logic [7:0] data;
		logic last;
		logic err;
	} beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [dlbd_pkg::IDX_W-1:0] cfg_index = '0;
	logic [dlbd_pkg::CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] rx_byte = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] payload_byte;
	logic last_byte;
	logic header_error;

	// register shadows
	logic reg_armed = 1'b0;
	logic [dlbd_pkg::RL_W-1:0] reg_rec_len = dlbd_pkg::RL_W'(1);
	logic [dlbd_pkg::BPP_W-1:0] reg_bpp = dlbd_pkg::BPP_W'(1);
	logic reg_multi = 1'b0;
	logic [dlbd_pkg::NR_W-1:0] reg_nrec = dlbd_pkg::NR_W'(1);

	// parser shadow
	logic [1:0] fr_phase = dlbd_pkg::PH_HUNT;
	logic [3:0] fr_digits = '0;
	logic [63:0] fr_accum = '0;
	logic fr_ovf = 1'b0;
	logic fr_bad = 1'b0;
	logic [63:0] fr_left = '0;

	beat_t expected_beats[$];
	int mismatch_count = 0;
	int items_sent = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_token = 0;
	int hold_seen = 0;
	int hold_left = 0;

	definite_length_block_deframer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.payload_byte(payload_byte),
		.last_byte(last_byte),
		.header_error(header_error)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// deframer shadow, stepped on every accepted input beat
	// ---------------------------------------------------------------

	function automatic void clear_parser();
		fr_phase = dlbd_pkg::PH_HUNT;
		fr_digits = '0;
		fr_accum = '0;
		fr_ovf = 1'b0;
		fr_bad = 1'b0;
		fr_left = '0;
	endfunction

	function automatic void push_reject();
		beat_t b;
		clear_parser();
		b.data = 8'h00;
		b.last = 1'b0;
		b.err = 1'b1;
		expected_beats.push_back(b);
	endfunction

	function automatic void deframe_byte(input logic [7:0] c);
		logic [63:0] d;
		logic [63:0] frames;
		logic [63:0] want;
		beat_t b;
		// disarmed: byte is dropped, state untouched
		if (!reg_armed) return;
		case (fr_phase)
			dlbd_pkg::PH_HUNT: begin
				if (c == dlbd_pkg::CHAR_HASH) fr_phase = dlbd_pkg::PH_NDIG;
			end
			dlbd_pkg::PH_NDIG: begin
				// digit count is one hex digit 1..f, either case; '0' is rejected
				if (c >= CH_1 && c <= CH_9) fr_digits = 4'(c - CH_0);
				else if (c >= CH_LA && c <= CH_LF) fr_digits = 4'(c - CH_LA + 8'd10);
				else if (c >= CH_UA && c <= CH_UF) fr_digits = 4'(c - CH_UA + 8'd10);
				else begin
					push_reject();
					return;
				end
				fr_accum = '0;
				fr_ovf = 1'b0;
				fr_bad = 1'b0;
				fr_phase = dlbd_pkg::PH_LEN;
			end
			dlbd_pkg::PH_LEN: begin
				if (c >= CH_0 && c <= CH_9) begin
					d = {56'd0, c - CH_0};
					// sticky overflow once the count passes the counter range
					if (!fr_ovf) begin
						if (fr_accum > (COUNT_MAX - d) / 64'd10) fr_ovf = 1'b1;
						else fr_accum = fr_accum * 64'd10 + d;
					end
				end else begin
					fr_bad = 1'b1;
				end
				fr_digits = fr_digits - 4'd1;
				if (fr_digits != 4'd0) return;
				// expected size is sampled at the last length digit
				frames = reg_multi ? {48'd0, reg_nrec} : 64'd1;
				want = {37'd0, reg_rec_len} * {62'd0, reg_bpp} * frames;
				if (fr_bad || fr_ovf || fr_accum == 64'd0 || fr_accum != want) begin
					push_reject();
					return;
				end
				fr_left = fr_accum;
				fr_phase = dlbd_pkg::PH_DATA;
			end
			default: begin
				b.data = c;
				b.err = 1'b0;
				if (fr_left <= 64'd1) begin
					b.last = 1'b1;
					clear_parser();
				end else begin
					b.last = 1'b0;
					fr_left = fr_left - 64'd1;
				end
				expected_beats.push_back(b);
			end
		endcase
	endfunction

	// ---------------------------------------------------------------
	// result checking
	// ---------------------------------------------------------------

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin : check_beat
		beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_beats.size() == 0) begin
				flag_mismatch("beat with nothing pending",
					{22'd0, payload_byte, last_byte, header_error}, 32'd0);
			end else begin
				want = expected_beats.pop_front();
				if (payload_byte !== want.data)
					flag_mismatch("payload_byte", {24'd0, payload_byte}, {24'd0, want.data});
				if (last_byte !== want.last)
					flag_mismatch("last_byte", {31'd0, last_byte}, {31'd0, want.last});
				if (header_error !== want.err)
					flag_mismatch("header_error", {31'd0, header_error}, {31'd0, want.err});
			end
		end
	end

	// receiver: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// watchdog: ends the run when no beat moves on either side for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
			else quiet++;
		end
		$display("Mismatches found");
		$finish;
	end

	// ---------------------------------------------------------------
	// drivers
	// ---------------------------------------------------------------

	// offer one byte, with random idle cycles ahead of it, and wait for the beat
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		deframe_byte(b);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	task automatic send_payload(input int n);
		repeat (n) send_byte(8'($urandom_range(0, 255)));
	endtask

	// drain: stop offering, wait for every pending result, then let the pipe empty
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write, only while the block is idle
	task automatic write_reg(input logic [dlbd_pkg::IDX_W-1:0] idx, input int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= dlbd_pkg::CFG_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			dlbd_pkg::REG_ARMED: begin
				reg_armed = val[0];
				clear_parser();
			end
			dlbd_pkg::REG_RECORD_LENGTH: reg_rec_len = val[dlbd_pkg::RL_W-1:0];
			dlbd_pkg::REG_BYTES_PER_POINT: reg_bpp = val[dlbd_pkg::BPP_W-1:0];
			dlbd_pkg::REG_MULTI_RECORD: reg_multi = val[0];
			dlbd_pkg::REG_NUM_RECORDS: reg_nrec = val[dlbd_pkg::NR_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic logic [63:0] block_size();
		logic [63:0] frames;
		frames = reg_multi ? {48'd0, reg_nrec} : 64'd1;
		return {37'd0, reg_rec_len} * {62'd0, reg_bpp} * frames;
	endfunction

	function automatic int num_digits(input logic [63:0] v);
		int n;
		n = 1;
		while (v >= 64'd10) begin
			v = v / 64'd10;
			n++;
		end
		return n;
	endfunction

	function automatic logic [7:0] count_char(input int n, input bit upper);
		if (n < 10) return 8'(CH_0 + n);
		return 8'((upper ? CH_UA : CH_LA) + n - 10);
	endfunction

	function automatic logic [7:0] non_digit();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b >= CH_0 && b <= CH_9);
		return b;
	endfunction

	function automatic logic [7:0] bad_count_char();
		logic [7:0] b;
		if ($urandom_range(0, 3) == 0) return CH_0;
		do b = 8'($urandom_range(0, 255));
		while ((b >= CH_1 && b <= CH_9) || (b >= CH_LA && b <= CH_LF)
			|| (b >= CH_UA && b <= CH_UF));
		return b;
	endfunction

	// '#', digit count, then the count zero-padded to ndig digits;
	// bad_pos >= 0 swaps that digit for a non-digit
	task automatic send_header(input int ndig, input logic [63:0] count, input bit upper,
			input int bad_pos);
		logic [7:0] digs [0:14];
		logic [63:0] v;
		v = count;
		for (int i = ndig - 1; i >= 0; i--) begin
			digs[i] = CH_0 + 8'(v % 64'd10);
			v = v / 64'd10;
		end
		if (bad_pos >= 0) digs[bad_pos] = non_digit();
		send_byte(dlbd_pkg::CHAR_HASH);
		send_byte(count_char(ndig, upper));
		for (int i = 0; i < ndig; i++) send_byte(digs[i]);
	endtask

	task automatic send_good_block();
		logic [63:0] size;
		size = block_size();
		send_header($urandom_range(num_digits(size), 15), size,
			1'($urandom_range(0, 1)), -1);
		send_payload(int'(size));
		// trailing bytes are hunted over
		case ($urandom_range(0, 3))
			0: send_byte(CH_LF_NL);
			1: begin
				send_byte(CH_CR);
				send_byte(CH_LF_NL);
			end
			default: ;
		endcase
	endtask

	task automatic random_config();
		if ($urandom_range(0, 9) == 0)
			write_reg(dlbd_pkg::REG_RECORD_LENGTH, $urandom_range(9, 40));
		else write_reg(dlbd_pkg::REG_RECORD_LENGTH, $urandom_range(1, 8));
		write_reg(dlbd_pkg::REG_BYTES_PER_POINT, $urandom_range(1, 2));
		write_reg(dlbd_pkg::REG_MULTI_RECORD, $urandom_range(0, 1));
		write_reg(dlbd_pkg::REG_NUM_RECORDS, $urandom_range(1, 4));
		if ($urandom_range(0, 1) == 0) write_reg(dlbd_pkg::REG_ARMED, 1);
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// after reset the block is disarmed, a full block gives nothing
	task automatic test_disarmed_input();
		send_text("#13abc");
		settle();
	endtask

	// plain block, payload extremes and a '#' inside the payload
	task automatic test_single_block();
		write_reg(dlbd_pkg::REG_ARMED, 1);
		write_reg(dlbd_pkg::REG_RECORD_LENGTH, 3);
		send_text("#13");
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(dlbd_pkg::CHAR_HASH);
		send_byte(CH_CR);
		send_byte(CH_LF_NL);
		// padded counts with upper and lower hex digit counts
		send_text("#A0000000003xyz");
		send_text("#f000000000000003");
		send_payload(3);
		settle();
	endtask

	task automatic test_header_rejects();
		// bad digit counts, including the ones next to the valid ranges
		send_text("#0#/#:#@#G#`#g##");
		send_text("#10");              // zero count
		send_text("#14");              // count differs from size
		send_text("#21x");             // non-digit in the length field
		send_text("#31#2");            // '#' inside the length field
		send_text("#F999999999999999");  // overflow
		send_text("#A2147483647");     // largest count, still a mismatch
		send_text("#A2147483648");     // one past the counter range
		send_text("#13abc");
		settle();
	endtask

	task automatic test_multi_record();
		write_reg(dlbd_pkg::REG_RECORD_LENGTH, 2);
		write_reg(dlbd_pkg::REG_BYTES_PER_POINT, 2);
		write_reg(dlbd_pkg::REG_MULTI_RECORD, 1);
		write_reg(dlbd_pkg::REG_NUM_RECORDS, 3);
		send_text("#212");
		send_payload(12);
		settle();
		// single frame mode ignores num_records
		write_reg(dlbd_pkg::REG_MULTI_RECORD, 0);
		send_text("#212#14");
		send_payload(4);
		settle();
	endtask

	// out-of-range settings are used as written
	task automatic test_odd_settings();
		write_reg(dlbd_pkg::REG_BYTES_PER_POINT, 0);
		send_text("#10#11q");
		settle();
		write_reg(dlbd_pkg::REG_BYTES_PER_POINT, 3);
		write_reg(dlbd_pkg::REG_RECORD_LENGTH, 1);
		send_text("#13");
		send_payload(3);
		settle();
		write_reg(dlbd_pkg::REG_RECORD_LENGTH, 0);
		write_reg(dlbd_pkg::REG_BYTES_PER_POINT, 1);
		send_text("#11q");
		settle();
		write_reg(dlbd_pkg::REG_RECORD_LENGTH, 1);
	endtask

	task automatic test_large_counts();
		// largest record length, single frame: header matches, block cut short by re-arm
		write_reg(dlbd_pkg::REG_RECORD_LENGTH, (1 << dlbd_pkg::RL_W) - 1);
		write_reg(dlbd_pkg::REG_BYTES_PER_POINT, 1);
		write_reg(dlbd_pkg::REG_MULTI_RECORD, 0);
		send_header(9, block_size(), 1'b0, -1);
		send_payload(3);
		settle();
		write_reg(dlbd_pkg::REG_ARMED, 1);
		// largest product is past the counter range
		write_reg(dlbd_pkg::REG_BYTES_PER_POINT, 3);
		write_reg(dlbd_pkg::REG_MULTI_RECORD, 1);
		write_reg(dlbd_pkg::REG_NUM_RECORDS, (1 << dlbd_pkg::NR_W) - 1);
		send_header(15, block_size(), 1'b1, -1);
		settle();
		// largest frame count
		write_reg(dlbd_pkg::REG_RECORD_LENGTH, 1);
		write_reg(dlbd_pkg::REG_BYTES_PER_POINT, 1);
		send_header(5, block_size(), 1'b0, -1);
		send_payload(2);
		settle();
		// disarm mid-block, bytes are dropped, re-arm starts a fresh hunt
		write_reg(dlbd_pkg::REG_ARMED, 0);
		send_text("#11z");
		settle();
		write_reg(dlbd_pkg::REG_ARMED, 1);
		write_reg(dlbd_pkg::REG_NUM_RECORDS, 1);
		send_text("#11z#31");
		settle();
		write_reg(dlbd_pkg::REG_ARMED, 1);
		send_text("#11k");
		settle();
	endtask

	// size is taken when the last length digit lands
	task automatic test_mid_header_change();
		write_reg(dlbd_pkg::REG_MULTI_RECORD, 0);
		send_text("#21");
		settle();
		write_reg(dlbd_pkg::REG_RECORD_LENGTH, 12);
		send_text("2");
		send_payload(12);
		settle();
	endtask

	// receiver holds off while the sender keeps offering, input must stall
	task automatic test_output_backpressure();
		write_reg(dlbd_pkg::REG_RECORD_LENGTH, 40);
		hold_token <= hold_token + 1;
		send_header(2, block_size(), 1'b0, -1);
		send_payload(40);
		settle();
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct,
			input int n_items);
		int stop_at;
		int kind;
		int ndig;
		logic [63:0] size;
		logic [63:0] cnt;
		send_idle_pct = send_pct;
		stall_pct = recv_pct;
		random_config();
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			kind = $urandom_range(0, 99);
			size = block_size();
			if (kind < 72) begin
				send_good_block();
			end else if (kind < 78) begin
				send_byte(dlbd_pkg::CHAR_HASH);
				send_byte(bad_count_char());
			end else if (kind < 84) begin
				cnt = $urandom_range(0, 1) ? size + 64'($urandom_range(1, 3)) : size - 64'd1;
				send_header($urandom_range(num_digits(cnt), 15), cnt,
					1'($urandom_range(0, 1)), -1);
			end else if (kind < 90) begin
				ndig = $urandom_range(num_digits(size), 15);
				send_header(ndig, size, 1'($urandom_range(0, 1)),
					$urandom_range(0, ndig - 1));
			end else if (kind < 94) begin
				send_header(15, 64'd100000000000000 + 64'($urandom),
					1'($urandom_range(0, 1)), -1);
			end else if (kind < 97) begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
			end else begin
				// header cut short, the next block's bytes land in the length field
				send_byte(dlbd_pkg::CHAR_HASH);
				send_byte(count_char($urandom_range(2, 4), 1'b0));
				send_byte(CH_1);
			end
			if ($urandom_range(0, 99) < 4) begin
				settle();
				random_config();
			end
		end
		settle();
		send_idle_pct = 0;
		stall_pct = 0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_disarmed_input();
		test_single_block();
		test_header_rejects();
		test_multi_record();
		test_odd_settings();
		test_large_counts();
		test_mid_header_change();
		test_output_backpressure();

		test_random_traffic(0, 0, 330);
		test_random_traffic(85, 0, 330);
		test_random_traffic(0, 85, 330);
		test_random_traffic(30, 30, 330);

		settle();
		if (expected_beats.size() != 0)
			flag_mismatch("results never delivered", expected_beats.size(), 32'd0);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/dlbd_pkg.sv
rtl/dlbd_size.sv
rtl/dlbd_parser.sv
rtl/definite_length_block_deframer.sv
dv/tb.sv
